// File: hdl/rsoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsoc_pkg;

   // Field widths fixed by the interface
   localparam int POS_W    = 13;
   localparam int CNT_W    = 13;
   localparam int BYTE_W   = 8;
   localparam int PLEN_W   = 4;
   localparam int PBYTES_W = 64;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W = 2;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Command codes
   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_APPEND = 2'd1;
   localparam cmd_type CMD_QUERY  = 2'd2;

   // Register indexes
   localparam csr_idx_type CSR_PATTERN_LENGTH = 2'd0;
   localparam csr_idx_type CSR_PATTERN_BYTES  = 2'd1;

endpackage

`default_nettype wire

// File: hdl/range_substring_occurrence_count.sv
`timescale 1ns / 1ps
`default_nettype none

// Counts occurrences of a pattern of up to PAT_MAX bytes in a text of up to
// TEXT_MAX bytes, overlapping matches included. Each append stores the running
// match count for its position in a prefix memory; a query [left,right] reads
// two prefix entries through the memory's two read ports and returns their
// difference. One command is taken per cycle while busy is low; busy is high
// only during reset and the cycle after it. The memory read is launched at the
// edge that accepts a query's start beat, and the difference is registered at
// the next edge, together with rsp_valid; the result beat stays for exactly one
// cycle and cannot be held off. Clear, append and unused commands give no
// result. Appends past TEXT_MAX are dropped. Pattern registers may only be written
// while no query is in flight.
module range_substring_occurrence_count #(
   parameter int TEXT_MAX = 4096,
   parameter int PAT_MAX  = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire rsoc_pkg::cmd_type               req_command,
   input  wire logic [rsoc_pkg::BYTE_W-1:0]     req_text_byte,
   input  wire logic [rsoc_pkg::POS_W-1:0]      req_range_left,
   input  wire logic [rsoc_pkg::POS_W-1:0]      req_range_right,
   output logic                                 rsp_valid,
   output logic      [rsoc_pkg::CNT_W-1:0]      rsp_occurrence_count,
   output logic                                 rsp_range_error,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire rsoc_pkg::csr_idx_type           csr_index,
   input  wire logic [rsoc_pkg::PBYTES_W-1:0]   csr_wdata
);
   import rsoc_pkg::*;

   localparam int LEN_W  = $clog2(TEXT_MAX + 1);
   localparam int ADDR_W = $clog2(TEXT_MAX);
   localparam int CW     = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   logic                 busy_ff;
   logic [PLEN_W-1:0]    plen_ff, plen_in;
   logic [PBYTES_W-1:0]  pbytes_ff, pbytes_in;
   logic [PLEN_W-1:0]    m_eff;

   logic                 accept;
   logic                 q_acc;
   logic [LEN_W-1:0]     text_len;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [CNT_W-1:0]     wr_data;
   logic [CNT_W-1:0]     rd_a;
   logic [CNT_W-1:0]     rd_b;

   logic [CW-1:0]        l_x, r_x, len_x, m_x, lo_x, ra_x, la_x;
   logic                 q_err, q_short, q_lo_zero;

   logic                 s1_valid_ff, s1_err_ff, s1_zero_ff, s1_lo_zero_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 rsp_valid_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;
   logic                 rsp_err_ff;

   // Hold off commands and register writes around reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;
   assign accept    = start && !busy_ff;
   assign q_acc     = accept && (req_command == CMD_QUERY);

   // Register file
   always_comb begin
      plen_in   = plen_ff;
      pbytes_in = pbytes_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: plen_in   = csr_wdata[PLEN_W-1:0];
            CSR_PATTERN_BYTES:  pbytes_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff   <= PLEN_W'(1);
         pbytes_ff <= '0;
      end else begin
         plen_ff   <= plen_in;
         pbytes_ff <= pbytes_in;
      end
   end

   // Clamp pattern length to 1..PAT_MAX
   always_comb begin
      m_eff = plen_ff;
      if (plen_ff == '0) begin
         m_eff = PLEN_W'(1);
      end else if (plen_ff > PLEN_W'(PAT_MAX)) begin
         m_eff = PLEN_W'(PAT_MAX);
      end
   end

   rsoc_append #(
      .TEXT_MAX (TEXT_MAX),
      .PAT_MAX  (PAT_MAX)
   ) u_append (
      .clock         (clock),
      .reset         (reset),
      .clear_en      (accept && (req_command == CMD_CLEAR)),
      .append_en     (accept && (req_command == CMD_APPEND)),
      .text_byte     (req_text_byte),
      .pattern_bytes (pbytes_ff),
      .pattern_len   (m_eff),
      .text_len      (text_len),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   // Decode the range: check bounds, find the two prefix positions
   assign l_x       = CW'(req_range_left);
   assign r_x       = CW'(req_range_right);
   assign len_x     = CW'(text_len);
   assign m_x       = CW'(m_eff);
   assign q_err     = (l_x == '0) || (l_x > r_x) || (r_x > len_x);
   assign lo_x      = l_x + m_x - CW'(2);
   assign q_short   = !(r_x > lo_x);
   assign q_lo_zero = (lo_x == '0);
   assign ra_x      = r_x - CW'(1);
   assign la_x      = lo_x - CW'(1);

   rsoc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (TEXT_MAX)
   ) u_prefix_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (q_acc),
      .rd_addr_a (ra_x[ADDR_W-1:0]),
      .rd_addr_b (la_x[ADDR_W-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Stage 1: track the query while the memory reads
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= q_acc;
      end
      s1_err_ff     <= q_err;
      s1_zero_ff    <= q_err || q_short;
      s1_lo_zero_ff <= q_lo_zero;
   end

   // Subtract the lower prefix, zero it at position zero; give zero for a bad or too short range
   assign cnt_in = s1_zero_ff ? '0 : (rd_a - (s1_lo_zero_ff ? '0 : rd_b));

   // Stage 2: present the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
      rsp_cnt_ff <= cnt_in;
      rsp_err_ff <= s1_err_ff;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrence_count = rsp_cnt_ff;
   assign rsp_range_error      = rsp_err_ff;

   // A result beat comes only from an accepted query
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(q_acc, 2))
      else $error("result beat without a matching query");

   // An erroneous range never reports a count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_occurrence_count == '0))
      else $error("range error with nonzero count");

   // Text never grows past capacity, and writes land at the current end
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (text_len < LEN_W'(TEXT_MAX)) && (ADDR_W'(text_len) == wr_addr))
      else $error("prefix write beyond text end");

endmodule

`default_nettype wire

// File: hdl/rsoc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rsoc_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read two with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// File: hdl/rsoc_append.sv
`timescale 1ns / 1ps
`default_nettype none

module rsoc_append #(
   parameter int TEXT_MAX = 4096,
   parameter int PAT_MAX  = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               clear_en,
   input  wire logic                               append_en,
   input  wire logic [rsoc_pkg::BYTE_W-1:0]        text_byte,
   input  wire logic [rsoc_pkg::PBYTES_W-1:0]      pattern_bytes,
   input  wire logic [rsoc_pkg::PLEN_W-1:0]        pattern_len,
   output logic      [$clog2(TEXT_MAX+1)-1:0]      text_len,
   output logic                                    wr_en,
   output logic      [$clog2(TEXT_MAX)-1:0]        wr_addr,
   output logic      [rsoc_pkg::CNT_W-1:0]         wr_data
);
   import rsoc_pkg::*;

   localparam int LEN_W = $clog2(TEXT_MAX + 1);
   localparam int ADDR_W = $clog2(TEXT_MAX);
   localparam int HIST_W = BYTE_W * PAT_MAX;

   logic [LEN_W-1:0]          len_ff, len_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [HIST_W-1:0]         hist_ff, hist_in;
   logic [HIST_W+BYTE_W-1:0]  window;
   logic                      full;
   logic                      long_enough;
   logic                      bytes_equal;
   logic                      take;

   assign window      = {hist_ff, text_byte};
   assign full        = (len_ff == LEN_W'(TEXT_MAX));
   assign take        = append_en && !full;
   assign len_in      = len_ff + LEN_W'(1);
   assign long_enough = ({1'b0, len_in} >= (LEN_W + 1)'(pattern_len));

   // Compare the newest bytes against the pattern, last pattern byte on the newest
   always_comb begin
      int k;
      bytes_equal = 1'b1;
      for (int j = 0; j < PAT_MAX; j++) begin
         k = int'(pattern_len) - 1 - j;
         if (k >= 0) begin
            if (window[BYTE_W*j +: BYTE_W] != pattern_bytes[BYTE_W*k +: BYTE_W]) begin
               bytes_equal = 1'b0;
            end
         end
      end
   end

   assign cnt_in  = cnt_ff + CNT_W'(long_enough && bytes_equal);
   assign hist_in = window[HIST_W-1:0];

   // Advance length, running count and byte history on each accepted append
   always_ff @(posedge clock) begin
      if (reset || clear_en) begin
         len_ff  <= '0;
         cnt_ff  <= '0;
         hist_ff <= '0;
      end else if (take) begin
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
         hist_ff <= hist_in;
      end
   end

   assign text_len = len_ff;
   assign wr_en    = take;
   assign wr_addr  = len_ff[ADDR_W-1:0];
   assign wr_data  = cnt_in;

endmodule

`default_nettype wire
